// ----- sv/lmpg_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lmpg_pkg
// Shared constants, codes and the raised-cosine wave table of the LED mode
// pattern generator.
// ----------------------------------------------------------------------------
package lmpg_pkg;

  // wave table size and the widths that follow from it
  localparam int unsigned COS_N = 256;
  localparam int unsigned IDX_W = $clog2(COS_N);
  localparam int unsigned Q_W   = (IDX_W > 8) ? IDX_W : 8;
  localparam int unsigned NUM_W = 16 + Q_W;
  localparam int unsigned REM_W = 20;
  localparam int unsigned WAVE_W = 17;

  localparam logic [REM_W-1:0] ACT_PERIOD = 20'd500;
  localparam int unsigned      FLASH_EDGES = 6;

  // mode codes
  localparam logic [2:0] OP_REMINDER     = 3'd0;
  localparam logic [2:0] OP_ACTIVATION   = 3'd1;
  localparam logic [2:0] OP_LISTENING    = 3'd2;
  localparam logic [2:0] OP_DEACTIVATION = 3'd3;

  // register indexes
  localparam logic [2:0] CFG_LIGHT_THR   = 3'd0;
  localparam logic [2:0] CFG_BRIGHT_MS   = 3'd1;
  localparam logic [2:0] CFG_MAX_BRIGHT  = 3'd2;
  localparam logic [2:0] CFG_DARK_MS     = 3'd3;
  localparam logic [2:0] CFG_DARK_OFF_MS = 3'd4;
  localparam logic [2:0] CFG_FLASH_MS    = 3'd5;
  localparam logic [2:0] CFG_LISTEN      = 3'd6;
  localparam logic [2:0] CFG_FADE_MS     = 3'd7;

  typedef enum logic [2:0] {
    K_ZERO,
    K_PEAK,
    K_LISTEN,
    K_BRIGHT,
    K_DARK,
    K_ACT,
    K_FADE
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] elap_lo;
  } side_t;

  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint          ONE_Q30 = 64'sd1073741824;

  // ceil(2^40 / (2k(2k+1))) for k = 1..7; exact floor division of a 32-bit term
  localparam int unsigned     RECIP_SH = 40;
  localparam longint unsigned TAYLOR_RECIP [7] = '{
    ((64'd1 << 40) + 64'd5)   / 64'd6,
    ((64'd1 << 40) + 64'd19)  / 64'd20,
    ((64'd1 << 40) + 64'd41)  / 64'd42,
    ((64'd1 << 40) + 64'd71)  / 64'd72,
    ((64'd1 << 40) + 64'd109) / 64'd110,
    ((64'd1 << 40) + 64'd155) / 64'd156,
    ((64'd1 << 40) + 64'd209) / 64'd210
  };

  typedef logic [WAVE_W-1:0] wave_tab_t [COS_N];

  // (1 - cos(2*pi*j/N)) / 2 as sin^2(pi*j/N), Taylor series in Q30
  function automatic logic [WAVE_W-1:0] wave_entry(int unsigned j);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned us;
    longint          s;
    int unsigned     jj;
    int unsigned     k;
    logic [79:0]     prod;
    jj = j;
    if (jj > COS_N) jj = COS_N;
    if (2 * jj > COS_N) jj = COS_N - jj;
    x    = (PI_Q30 * longint'(jj)) / COS_N;
    x2   = (x * x) >> 30;
    term = x;
    s    = longint'(term);
    for (k = 1; k <= 7; k++) begin
      term = (term * x2) >> 30;
      prod = 80'(term) * 80'(TAYLOR_RECIP[k-1]);
      term = 64'(prod >> RECIP_SH);
      if (k[0]) s = s - longint'(term);
      else      s = s + longint'(term);
    end
    if (s < 0) s = 0;
    if (s > ONE_Q30) s = ONE_Q30;
    us = longint'(s);
    return WAVE_W'((us * us + (64'd1 << 43)) >> 44);
  endfunction

  function automatic wave_tab_t wave_build();
    wave_tab_t t;
    for (int unsigned j = 0; j < COS_N; j++) begin
      t[j] = wave_entry(j);
    end
    return t;
  endfunction

  localparam wave_tab_t WAVE = wave_build();

endpackage
`default_nettype wire

// ----- sv/lmpg_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lmpg_if
// Query and result channels of the LED mode pattern generator.
// ----------------------------------------------------------------------------
interface lmpg_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [31:0] mode_start_ms;
  logic [31:0] now_ms;
  logic [6:0]  light_level;

  modport source (output valid, op, mode_start_ms, now_ms, light_level, input ready);
  modport sink   (input valid, op, mode_start_ms, now_ms, light_level, output ready);
endinterface

interface lmpg_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] brightness;

  modport source (output valid, brightness, input ready);
  modport sink   (input valid, brightness, output ready);
endinterface
`default_nettype wire

// ----- sv/lmpg_mod_pipe.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lmpg_mod_pipe
// Pipelined restoring remainder: one dividend bit per stage, 32 stages.
// ----------------------------------------------------------------------------
module lmpg_mod_pipe (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       en_i,
  input  wire logic                       in_valid_i,
  input  wire logic [31:0]                dividend_i,
  input  wire logic [lmpg_pkg::REM_W-1:0] divisor_i,
  input  wire lmpg_pkg::side_t            side_i,
  output logic                            out_valid_o,
  output logic [lmpg_pkg::REM_W-1:0]      rem_o,
  output lmpg_pkg::side_t                 side_o
);

  localparam int unsigned STAGES = 32;
  localparam int unsigned RW     = lmpg_pkg::REM_W;

  logic                 vld_q  [STAGES];
  logic [RW-1:0]        rem_q  [STAGES];
  logic [RW-1:0]        den_q  [STAGES];
  logic [31:0]          num_q  [STAGES];
  lmpg_pkg::side_t      side_q [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_st
    logic            vld_in;
    logic [RW-1:0]   rem_in;
    logic [RW-1:0]   den_in;
    logic [31:0]     num_in;
    lmpg_pkg::side_t side_in;
    logic [RW:0]     trial;
    logic [RW-1:0]   rem_d;

    if (s == 0) begin : g_first
      assign vld_in  = in_valid_i;
      assign rem_in  = '0;
      assign den_in  = divisor_i;
      assign num_in  = dividend_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign den_in  = den_q[s-1];
      assign num_in  = num_q[s-1];
      assign side_in = side_q[s-1];
    end

    always_comb begin
      trial = {rem_in, num_in[31]};
      if (trial >= {1'b0, den_in}) rem_d = RW'(trial - {1'b0, den_in});
      else                         rem_d = trial[RW-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_d;
        den_q[s]  <= den_in;
        num_q[s]  <= {num_in[30:0], 1'b0};
        side_q[s] <= side_in;
      end
    end
  end

  assign out_valid_o = vld_q[STAGES-1];
  assign rem_o       = rem_q[STAGES-1];
  assign side_o      = side_q[STAGES-1];

endmodule
`default_nettype wire

// ----- sv/led_mode_pattern_generator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// led_mode_pattern_generator
// Stateless LED brightness query: breath, flash, constant and fade patterns.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  in_ch     sink       valid/ready          op, mode_start_ms, now_ms,
//                                            light_level
//  out_ch    source     valid/ready          brightness
//  cfg       sink       cfg_we_i (no wait)   cfg_idx_i, cfg_data_i
//
//  One query per cycle when not stalled. Stages: input, 32-stage remainder
//  pipeline, select, 8-stage phase/fade divider, table and multiply.
//  The remainder pipeline sets the latency; every stage takes one bit.
//  Reset clears all valid bits and loads the register defaults.
//  A stalled result holds the whole pipeline; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module led_mode_pattern_generator (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lmpg_in_if.sink    in_ch,
  lmpg_out_if.source out_ch,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int unsigned RW  = lmpg_pkg::REM_W;
  localparam int unsigned QW  = lmpg_pkg::Q_W;
  localparam int unsigned NW  = lmpg_pkg::NUM_W;
  localparam int unsigned IW  = lmpg_pkg::IDX_W;
  localparam int unsigned WW  = lmpg_pkg::WAVE_W;
  localparam int unsigned NFE = lmpg_pkg::FLASH_EDGES;

  typedef enum logic [1:0] {
    R_DIRECT,
    R_BREATH,
    R_FADE
  } res_e;

  // configuration
  logic [6:0]  thr_q;
  logic [15:0] bright_q;
  logic [7:0]  peak_q;
  logic [15:0] dark_q;
  logic [15:0] off_q;
  logic [15:0] flash_q;
  logic [7:0]  listen_q;
  logic [15:0] fade_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= 7'd30;
      bright_q <= 16'd4000;
      peak_q   <= 8'd255;
      dark_q   <= 16'd3000;
      off_q    <= 16'd500;
      flash_q  <= 16'd150;
      listen_q <= 8'd128;
      fade_q   <= 16'd1000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lmpg_pkg::CFG_LIGHT_THR:   thr_q    <= cfg_data_i[6:0];
        lmpg_pkg::CFG_BRIGHT_MS:   bright_q <= cfg_data_i;
        lmpg_pkg::CFG_MAX_BRIGHT:  peak_q   <= cfg_data_i[7:0];
        lmpg_pkg::CFG_DARK_MS:     dark_q   <= cfg_data_i;
        lmpg_pkg::CFG_DARK_OFF_MS: off_q    <= cfg_data_i;
        lmpg_pkg::CFG_FLASH_MS:    flash_q  <= cfg_data_i;
        lmpg_pkg::CFG_LISTEN:      listen_q <= cfg_data_i[7:0];
        lmpg_pkg::CFG_FADE_MS:     fade_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // dark cycle length and segment edges, used a stage or more after entry
  logic [RW-1:0] cyc_q;
  logic [RW-1:0] edge_q [NFE];

  always_ff @(posedge clk_i) begin
    cyc_q <= RW'(dark_q) + (RW'(off_q) << 1) + RW'(flash_q) * RW'(NFE);
    for (int k = 0; k < NFE; k++) begin
      edge_q[k] <= RW'(dark_q) + RW'(off_q) + RW'(flash_q) * RW'(k);
    end
  end

  logic en;
  logic out_valid_q;
  logic [7:0] out_q;

  assign en          = !out_valid_q || out_ch.ready;
  assign in_ch.ready = en;

  // ---------------- input stage ----------------
  logic [31:0]   elapsed;
  lmpg_pkg::kind_e s0_kind_d;

  always_comb begin
    elapsed = in_ch.now_ms - in_ch.mode_start_ms;
    case (in_ch.op)
      lmpg_pkg::OP_REMINDER: begin
        if (in_ch.light_level >= thr_q) begin
          s0_kind_d = (bright_q == '0) ? lmpg_pkg::K_PEAK : lmpg_pkg::K_BRIGHT;
        end else if (dark_q == '0 && off_q == '0 && flash_q == '0) begin
          s0_kind_d = lmpg_pkg::K_ZERO;
        end else begin
          s0_kind_d = lmpg_pkg::K_DARK;
        end
      end
      lmpg_pkg::OP_ACTIVATION: s0_kind_d = lmpg_pkg::K_ACT;
      lmpg_pkg::OP_LISTENING:  s0_kind_d = lmpg_pkg::K_LISTEN;
      lmpg_pkg::OP_DEACTIVATION: begin
        s0_kind_d = (elapsed >= 32'(fade_q)) ? lmpg_pkg::K_ZERO : lmpg_pkg::K_FADE;
      end
      default: s0_kind_d = lmpg_pkg::K_ZERO;
    endcase
  end

  logic            s0_vld_q;
  logic [31:0]     s0_elap_q;
  lmpg_pkg::side_t s0_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_elap_q         <= elapsed;
      s0_side_q.kind    <= s0_kind_d;
      s0_side_q.elap_lo <= elapsed[15:0];
    end
  end

  // ---------------- remainder pipeline ----------------
  logic [RW-1:0]   mod_den;
  logic            mod_vld;
  logic [RW-1:0]   mod_rem;
  lmpg_pkg::side_t mod_side;

  always_comb begin
    case (s0_side_q.kind)
      lmpg_pkg::K_BRIGHT: mod_den = RW'(bright_q);
      lmpg_pkg::K_DARK:   mod_den = cyc_q;
      lmpg_pkg::K_ACT:    mod_den = lmpg_pkg::ACT_PERIOD;
      default:            mod_den = RW'(1);
    endcase
  end

  lmpg_mod_pipe u_mod (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (s0_vld_q),
    .dividend_i  (s0_elap_q),
    .divisor_i   (mod_den),
    .side_i      (s0_side_q),
    .out_valid_o (mod_vld),
    .rem_o       (mod_rem),
    .side_o      (mod_side)
  );

  // ---------------- select stage ----------------
  res_e          m_res_d;
  logic [7:0]    m_val_d;
  logic [NW-1:0] m_num_d;
  logic [15:0]   m_den_d;
  logic [NW-1:0] rem_scaled;

  always_comb begin
    rem_scaled = NW'(mod_rem[15:0]) * NW'(lmpg_pkg::COS_N);
    m_res_d    = R_DIRECT;
    m_val_d    = '0;
    m_num_d    = rem_scaled;
    m_den_d    = 16'd1;
    case (mod_side.kind)
      lmpg_pkg::K_BRIGHT: begin
        m_res_d = R_BREATH;
        m_den_d = bright_q;
      end
      lmpg_pkg::K_ACT: begin
        m_res_d = R_BREATH;
        m_den_d = 16'(lmpg_pkg::ACT_PERIOD);
      end
      lmpg_pkg::K_DARK: begin
        if (mod_rem < RW'(dark_q)) begin
          m_res_d = R_BREATH;
          m_den_d = dark_q;
        end else if (mod_rem < edge_q[1]) begin
          // off gap or first flash on
          m_val_d = (mod_rem < edge_q[0]) ? 8'd0 : peak_q;
        end else if (mod_rem >= edge_q[2] && mod_rem < edge_q[3]) begin
          m_val_d = peak_q;
        end else if (mod_rem >= edge_q[4] && mod_rem < edge_q[5]) begin
          m_val_d = peak_q;
        end
      end
      lmpg_pkg::K_PEAK:   m_val_d = peak_q;
      lmpg_pkg::K_LISTEN: m_val_d = listen_q;
      lmpg_pkg::K_FADE: begin
        m_res_d = R_FADE;
        m_num_d = NW'(listen_q) * NW'(mod_side.elap_lo);
        m_den_d = fade_q;
      end
      default: ;
    endcase
  end

  logic          m_vld_q;
  res_e          m_res_q;
  logic [7:0]    m_val_q;
  logic [NW-1:0] m_num_q;
  logic [15:0]   m_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (en) begin
      m_vld_q <= mod_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_res_q <= m_res_d;
      m_val_q <= m_val_d;
      m_num_q <= m_num_d;
      m_den_q <= m_den_d;
    end
  end

  // ---------------- phase / fade divider, one quotient bit a stage ----------
  logic          d_vld_q  [QW];
  res_e          d_res_q  [QW];
  logic [7:0]    d_val_q  [QW];
  logic [15:0]   d_rem_q  [QW];
  logic [QW-1:0] d_bits_q [QW];
  logic [QW-1:0] d_quo_q  [QW];
  logic [15:0]   d_den_q  [QW];

  for (genvar s = 0; s < QW; s++) begin : g_div
    logic          vld_in;
    res_e          res_in;
    logic [7:0]    val_in;
    logic [15:0]   rem_in;
    logic [QW-1:0] bits_in;
    logic [QW-1:0] quo_in;
    logic [15:0]   den_in;
    logic [16:0]   trial;
    logic          ge;

    if (s == 0) begin : g_first
      assign vld_in  = m_vld_q;
      assign res_in  = m_res_q;
      assign val_in  = m_val_q;
      assign rem_in  = m_num_q[NW-1:QW];
      assign bits_in = m_num_q[QW-1:0];
      assign quo_in  = '0;
      assign den_in  = m_den_q;
    end else begin : g_next
      assign vld_in  = d_vld_q[s-1];
      assign res_in  = d_res_q[s-1];
      assign val_in  = d_val_q[s-1];
      assign rem_in  = d_rem_q[s-1];
      assign bits_in = d_bits_q[s-1];
      assign quo_in  = d_quo_q[s-1];
      assign den_in  = d_den_q[s-1];
    end

    assign trial = {rem_in, bits_in[QW-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        d_vld_q[s] <= 1'b0;
      end else if (en) begin
        d_vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        d_res_q[s]  <= res_in;
        d_val_q[s]  <= val_in;
        d_rem_q[s]  <= ge ? 16'(trial - {1'b0, den_in}) : trial[15:0];
        d_bits_q[s] <= bits_in << 1;
        d_quo_q[s]  <= {quo_in[QW-2:0], ge};
        d_den_q[s]  <= den_in;
      end
    end
  end

  // ---------------- table stage ----------------
  logic [QW-1:0] quo;
  logic [IW-1:0] idx;

  assign quo = d_quo_q[QW-1];
  assign idx = ({1'b0, quo} >= (QW+1)'(lmpg_pkg::COS_N)) ?
               IW'(lmpg_pkg::COS_N - 1) : quo[IW-1:0];

  logic          t_vld_q;
  res_e          t_res_q;
  logic [7:0]    t_val_q;
  logic [7:0]    t_quo_q;
  logic [WW-1:0] t_wave_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_vld_q <= 1'b0;
    end else if (en) begin
      t_vld_q <= d_vld_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_res_q  <= d_res_q[QW-1];
      t_val_q  <= d_val_q[QW-1];
      t_quo_q  <= quo[7:0];
      t_wave_q <= lmpg_pkg::WAVE[idx];
    end
  end

  // ---------------- scale and output register ----------------
  logic [WW+7:0] prod;
  logic [7:0]    out_d;

  always_comb begin
    prod = (WW+8)'(t_wave_q) * (WW+8)'(peak_q);
    case (t_res_q)
      R_BREATH: out_d = prod[23:16];
      R_FADE:   out_d = listen_q - t_quo_q;
      default:  out_d = t_val_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= t_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_ch.valid      = out_valid_q;
  assign out_ch.brightness = out_q;

endmodule
`default_nettype wire

// ----- sv/lmpg_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lmpg_checker
// Port-level checks of the LED mode pattern generator, bound to the top level.
// ----------------------------------------------------------------------------
module lmpg_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] brightness_i
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(brightness_i))
    else $error("stalled brightness changed");

  // the input side stalls only behind a waiting result
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_i || out_ready_i) |-> in_ready_i)
    else $error("query refused with a free output");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("result shown after reset");

  a_no_stale_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !(in_valid_i && in_ready_i))
    else $error("query taken while the pipeline is held");

endmodule

bind led_mode_pattern_generator lmpg_checker u_lmpg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_ch.valid),
  .in_ready_i   (in_ch.ready),
  .out_valid_i  (out_ch.valid),
  .out_ready_i  (out_ch.ready),
  .brightness_i (out_ch.brightness)
);
`default_nettype wire

// ----- sim/led_mode_pattern_generator_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// led_mode_pattern_generator_tb
// Checks every brightness result against a local prediction of the breath,
// dark cycle, constant and fade patterns over several register settings, with
// random idling on both channels and a long result stall.
// ----------------------------------------------------------------------------
module led_mode_pattern_generator_tb;

  localparam int LATENCY = 44;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  lmpg_in_if  in_ch ();
  lmpg_out_if out_ch ();

  led_mode_pattern_generator u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch.sink),
    .out_ch     (out_ch.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // register copies
  logic [6:0]  thr_pct;
  logic [15:0] bright_ms, dark_ms, dark_off, flash_len, fade_len;
  logic [7:0]  peak, listen_lvl;
  logic [16:0] wave_q16 [lmpg_pkg::COS_N];

  logic [7:0] expected_levels [$];
  int  mismatches = 0;
  bit  idle_on = 1'b1;
  bit  hold_off = 1'b0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.op = '0;
    in_ch.mode_start_ms = '0;
    in_ch.now_ms = '0;
    in_ch.light_level = '0;
    out_ch.ready = 1'b0;
  end

  // sine-squared table in Q30 arithmetic, built locally
  function automatic logic [16:0] wave_calc(int unsigned j);
    longint unsigned x, x2, term, us;
    longint s;
    int unsigned jj;
    jj = j;
    if (2 * jj > lmpg_pkg::COS_N) jj = lmpg_pkg::COS_N - jj;
    x = (64'd3373259426 * jj) / lmpg_pkg::COS_N;
    x2 = (x * x) >> 30;
    term = x;
    s = term;
    for (int k = 1; k <= 7; k++) begin
      term = (term * x2) >> 30;
      term = term / ((2 * k) * (2 * k + 1));
      if (k % 2) s = s - longint'(term);
      else s = s + longint'(term);
    end
    if (s < 0) s = 0;
    if (s > 64'sd1073741824) s = 64'sd1073741824;
    us = s;
    return 17'((us * us + (64'd1 << 43)) >> 44);
  endfunction

  function automatic logic [7:0] breath_level(logic [31:0] t, logic [31:0] period,
                                              logic [7:0] pk);
    longint unsigned idx;
    if (period == 0) return pk;
    idx = (longint'(t % period) * lmpg_pkg::COS_N) / period;
    if (idx >= lmpg_pkg::COS_N) idx = lmpg_pkg::COS_N - 1;
    return 8'((longint'(wave_q16[idx]) * pk) >> 16);
  endfunction

  function automatic logic [7:0] predict_level(logic [2:0] op, logic [31:0] start,
                                               logic [31:0] now, logic [6:0] light);
    logic [31:0] el, pair, cyc, pos;
    el = now - start;
    case (op)
      lmpg_pkg::OP_REMINDER: begin
        if (light >= thr_pct) return breath_level(el, bright_ms, peak);
        pair = flash_len * 2;
        cyc = dark_ms + dark_off + pair * 3 + dark_off;
        if (cyc == 0) return 0;
        pos = el % cyc;
        if (pos < dark_ms) return breath_level(pos, dark_ms, peak);
        pos -= dark_ms;
        if (pos < dark_off) return 0;
        pos -= dark_off;
        if (pos < pair * 3) return ((pos % pair) < flash_len) ? peak : 8'd0;
        return 0;
      end
      lmpg_pkg::OP_ACTIVATION:   return breath_level(el, 500, peak);
      lmpg_pkg::OP_LISTENING:    return listen_lvl;
      lmpg_pkg::OP_DEACTIVATION: begin
        if (el >= fade_len) return 0;
        return 8'(listen_lvl - (longint'(listen_lvl) * el) / fade_len);
      end
      default:         return 0;
    endcase
  endfunction

  task automatic idle_gap();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  task automatic send_query(logic [2:0] op, logic [31:0] start, logic [31:0] now,
                            logic [6:0] light);
    idle_gap();
    in_ch.valid         <= 1'b1;
    in_ch.op            <= op;
    in_ch.mode_start_ms <= start;
    in_ch.now_ms        <= now;
    in_ch.light_level   <= light;
    do @(posedge clk_i); while (!in_ch.ready);
    expected_levels.push_back(predict_level(op, start, now, light));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      lmpg_pkg::CFG_LIGHT_THR:   thr_pct    = val[6:0];
      lmpg_pkg::CFG_BRIGHT_MS:   bright_ms  = val;
      lmpg_pkg::CFG_MAX_BRIGHT:  peak       = val[7:0];
      lmpg_pkg::CFG_DARK_MS:     dark_ms    = val;
      lmpg_pkg::CFG_DARK_OFF_MS: dark_off   = val;
      lmpg_pkg::CFG_FLASH_MS:    flash_len  = val;
      lmpg_pkg::CFG_LISTEN:      listen_lvl = val[7:0];
      lmpg_pkg::CFG_FADE_MS:     fade_len   = val;
      default: ;
    endcase
  endtask

  task automatic random_query();
    logic [31:0] start, span;
    case ($urandom_range(0, 3))
      0: span = $urandom;
      1: span = $urandom_range(0, 300000);
      default: span = $urandom_range(0, 70000);
    endcase
    start = $urandom;
    send_query(3'($urandom_range(0, 7)), start, start + span,
               ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, 100)));
  endtask

  // results: compare with the oldest expectation
  always @(posedge clk_i) begin
    if (out_ch.valid && out_ch.ready) begin
      if (expected_levels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d", out_ch.brightness);
      end else begin
        if (out_ch.brightness !== expected_levels[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("brightness: expected %0d, got %0d", expected_levels[0],
                     out_ch.brightness);
        end
        void'(expected_levels.pop_front());
      end
    end
  end

  // receiver stalls
  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (hold_off) out_ch.ready <= 1'b0;
      else if (idle_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 8);
        out_ch.ready <= 1'b0;
        repeat (n - 1) @(posedge clk_i);
      end else out_ch.ready <= 1'b1;
    end
  end

  task automatic test_defaults();
    for (int op = 0; op < 8; op++) send_query(3'(op), 32'd0, 32'd1234, 7'd50);
    send_query(lmpg_pkg::OP_REMINDER, 32'hFFFF_FFFF, 32'd0, 7'd0);
    send_query(lmpg_pkg::OP_REMINDER, 32'd0, 32'hFFFF_FFFF, 7'd127);
    send_query(lmpg_pkg::OP_REMINDER, 32'd0, 32'd3600, 7'd29);
    send_query(lmpg_pkg::OP_REMINDER, 32'd0, 32'd4100, 7'd10);
    send_query(lmpg_pkg::OP_REMINDER, 32'd0, 32'd5050, 7'd30);
    send_query(lmpg_pkg::OP_DEACTIVATION, 32'd100, 32'd1099, 7'd0);
    send_query(lmpg_pkg::OP_DEACTIVATION, 32'd100, 32'd1100, 7'd0);
    send_query(lmpg_pkg::OP_ACTIVATION, 32'd0, 32'd250, 7'd100);
    drain();
  endtask

  task automatic test_extremes();
    write_reg(lmpg_pkg::CFG_LIGHT_THR, 16'd127);
    write_reg(lmpg_pkg::CFG_BRIGHT_MS, 16'd0);
    write_reg(lmpg_pkg::CFG_MAX_BRIGHT, 16'd0);
    write_reg(lmpg_pkg::CFG_DARK_MS, 16'd0);
    write_reg(lmpg_pkg::CFG_DARK_OFF_MS, 16'd0);
    write_reg(lmpg_pkg::CFG_FLASH_MS, 16'd0);
    write_reg(lmpg_pkg::CFG_LISTEN, 16'd0);
    write_reg(lmpg_pkg::CFG_FADE_MS, 16'd0);
    send_query(lmpg_pkg::OP_REMINDER, 32'd0, 32'd77, 7'd0);
    send_query(lmpg_pkg::OP_REMINDER, 32'd0, 32'd77, 7'd127);
    send_query(lmpg_pkg::OP_DEACTIVATION, 32'd0, 32'd0, 7'd0);
    send_query(lmpg_pkg::OP_LISTENING, 32'd0, 32'd0, 7'd0);
    drain();
    write_reg(lmpg_pkg::CFG_LIGHT_THR, 16'd0);
    write_reg(lmpg_pkg::CFG_BRIGHT_MS, 16'hFFFF);
    write_reg(lmpg_pkg::CFG_MAX_BRIGHT, 16'hFFFF);
    write_reg(lmpg_pkg::CFG_DARK_MS, 16'hFFFF);
    write_reg(lmpg_pkg::CFG_DARK_OFF_MS, 16'hFFFF);
    write_reg(lmpg_pkg::CFG_FLASH_MS, 16'hFFFF);
    write_reg(lmpg_pkg::CFG_LISTEN, 16'hFFFF);
    write_reg(lmpg_pkg::CFG_FADE_MS, 16'hFFFF);
    send_query(lmpg_pkg::OP_REMINDER, 32'd0, 32'd65534, 7'd0);
    send_query(lmpg_pkg::OP_DEACTIVATION, 32'd0, 32'd65534, 7'd0);
    send_query(lmpg_pkg::OP_DEACTIVATION, 32'd0, 32'd1, 7'd0);
    drain();
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(lmpg_pkg::CFG_LIGHT_THR, 16'($urandom_range(0, 110)));
      write_reg(lmpg_pkg::CFG_BRIGHT_MS, ph == 0 ? 16'd1 : 16'($urandom_range(0, 8000)));
      write_reg(lmpg_pkg::CFG_MAX_BRIGHT, 16'($urandom_range(0, 255)));
      write_reg(lmpg_pkg::CFG_DARK_MS, 16'($urandom_range(0, 5000)));
      write_reg(lmpg_pkg::CFG_DARK_OFF_MS, 16'($urandom_range(0, 1000)));
      write_reg(lmpg_pkg::CFG_FLASH_MS,
                ph == 1 ? 16'($urandom) : 16'($urandom_range(0, 300)));
      write_reg(lmpg_pkg::CFG_LISTEN, 16'($urandom_range(0, 255)));
      write_reg(lmpg_pkg::CFG_FADE_MS,
                ph == 2 ? 16'($urandom) : 16'($urandom_range(1, 3000)));
      for (int i = 0; i < 250; i++) random_query();
      drain();
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 100; i++) random_query();
    join
    drain();
  endtask

  task automatic test_streaming();
    idle_on = 1'b0;
    for (int i = 0; i < 100; i++) random_query();
    drain();
  endtask

  initial begin
    for (int j = 0; j < lmpg_pkg::COS_N; j++) wave_q16[j] = wave_calc(j);
    thr_pct = 30; bright_ms = 4000; peak = 255; dark_ms = 3000;
    dark_off = 500; flash_len = 150; listen_lvl = 128; fade_len = 1000;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults();
    test_extremes();
    test_random();
    test_backpressure();
    test_streaming();
    if (mismatches == 0 && expected_levels.size() == 0)
      $display("led_mode_pattern_generator: match");
    else
      $display("led_mode_pattern_generator: mismatch");
    $finish;
  end

  initial begin
    #400000;
    $display("led_mode_pattern_generator: mismatch");
    $finish;
  end
endmodule

// ----- filelist.f -----
sv/lmpg_pkg.sv
sv/lmpg_if.sv
sv/lmpg_mod_pipe.sv
sv/led_mode_pattern_generator.sv
sv/lmpg_checker.sv
sim/led_mode_pattern_generator_tb.sv
